/* rtl/sha256_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash words and shared control types.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 61;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic       put;       // write byte into block buffer
    logic [5:0] pos;       // byte position
    logic [7:0] byte_val;  // byte value
    logic       put_len;   // write bit length into words 14 and 15
    logic       start;     // load working vars from chaining value
    logic       round;     // perform one round
    logic       finish;    // add working vars into chaining value
    logic       init;      // reload initial hash words, clear count
    logic       cnt_inc;   // advance byte count
  } sha_cmd_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic              round_last;
  } sha_sts_t;

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    unique case (t)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_h(input logic [2:0] i);
    word_t h;
    unique case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

endpackage

`default_nettype wire

/* rtl/sha256_byte_stream_hasher.sv */
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes one byte-stream message per run and emits eight digest words.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while idle; every 64th byte holds off input
// for a compression (start, rounds, finish). Last item: padding, one or two
// compressions, then eight digest words, one per cycle while tready is high.
// Reset: asynchronous, active low; returns to idle with initial hash words.
`default_nettype none

module sha256_byte_stream_hasher
  import sha256_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // data_byte
  input  wire logic        s_axis_tlast_i,   // is_last
  input  wire logic        s_axis_tuser_i,   // no_data
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o,   // digest_word[31:0], word_index[34:32], 0
  output logic             m_axis_tlast_o    // last_word
);

  sha_cmd_t    cmd;
  sha_sts_t    sts;
  word_t [7:0] hash;
  logic [2:0]  idx;

  sha256_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_byte_i   (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .in_none_i   (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_idx_o   (idx),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  sha256_dp u_dp (
    .clk_i, .rst_ni,
    .cmd_i  (cmd),
    .sts_o  (sts),
    .hash_o (hash)
  );

  assign m_axis_tdata_o = {5'd0, idx, hash[idx]};
  assign m_axis_tlast_o = (idx == 3'd7);

endmodule

`default_nettype wire

/* rtl/sha256_dp.sv */
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, message schedule, working variables, chaining value, count.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_dp
  import sha256_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  sha_cmd_t      cmd_i,
  output sha_sts_t      sts_o,
  output word_t [7:0]   hash_o
);

  word_t [15:0]      w_q;
  word_t [7:0]       v_q;
  word_t [7:0]       h_q;
  logic [5:0]        t_q;
  logic [CountW-1:0] cnt_q;

  word_t x15, x2, s0, s1, wt, wn, e, a, t1, t2;
  logic [63:0] bits;

  function automatic word_t ror(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  always_comb begin
    x15 = w_q[1];
    x2  = w_q[14];
    s0  = ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3);
    s1  = ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10);
    wn  = w_q[0] + s0 + w_q[9] + s1;
    wt  = (t_q < 6'd16) ? w_q[0] : wn;
    e   = v_q[4];
    a   = v_q[0];
    t1  = v_q[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) +
          ((e & v_q[5]) ^ (~e & v_q[6])) + round_k(t_q) + wt;
    t2  = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) +
          ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
    bits = {cnt_q, 3'b000};
  end

  // schedule window rotates: w_q[0] holds the word of rounds 0-15; later words are computed from the window
  always_ff @(posedge clk_i) begin
    if (cmd_i.put) begin
      w_q[cmd_i.pos[5:2]][8*(3-cmd_i.pos[1:0]) +: 8] <= cmd_i.byte_val;
    end else if (cmd_i.put_len) begin
      w_q[14] <= bits[63:32];
      w_q[15] <= bits[31:0];
    end else if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wt;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end else if (cmd_i.start) begin
      v_q <= h_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
      t_q   <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.round) t_q <= t_q + 6'd1;
      if (cmd_i.cnt_inc) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.finish) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (cmd_i.init) begin
        for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
        cnt_q <= '0;
      end
    end
  end

  assign sts_o.count      = cnt_q;
  assign sts_o.round_last = (t_q == 6'd63);
  assign hash_o           = h_q;

endmodule

`default_nettype wire

/* rtl/sha256_ctrl.sv */
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte intake, padding, compression and digest output.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_ctrl
  import sha256_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  output logic        in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic   in_last_i,
  input  wire logic   in_none_i,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output logic [2:0]  out_idx_o,
  output sha_cmd_t    cmd_o,
  input  sha_sts_t    sts_i
);

  typedef enum logic [2:0] {
    StIdle, StStart, StRound, StFinish, StPad, StLen, StOut
  } state_e;

  state_e     state_q;
  logic       pad_q;      // padding phase active
  logic       two_q;      // length needs an extra block
  logic [5:0] pos_q;
  logic [2:0] idx_q;
  logic       acc;
  logic [5:0] cpos;

  assign cpos        = sts_i.count[5:0];
  assign in_ready_o  = (state_q == StIdle);
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == StOut);
  assign out_idx_o   = idx_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      StIdle: begin
        cmd_o.pos      = cpos;
        cmd_o.byte_val = in_byte_i;
        cmd_o.put      = acc && !in_none_i;
        cmd_o.cnt_inc  = acc && !in_none_i;
      end
      StStart:  cmd_o.start  = 1'b1;
      StRound:  cmd_o.round  = 1'b1;
      StFinish: cmd_o.finish = 1'b1;
      StPad: begin
        cmd_o.put      = 1'b1;
        cmd_o.pos      = pos_q;
        cmd_o.byte_val = (pos_q == cpos && !two_q) ? PadByte : 8'h00;
      end
      StLen:    cmd_o.put_len = 1'b1;
      StOut:    cmd_o.init    = out_ready_i && (idx_q == 3'd7);
      default: ;
    endcase
  end

  // two_q: 0 = 0x80 goes into this block, 1 = written in earlier block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pad_q   <= 1'b0;
      two_q   <= 1'b0;
      pos_q   <= '0;
      idx_q   <= '0;
    end else begin
      unique case (state_q)
        StIdle: if (acc) begin
          pad_q <= in_last_i;
          two_q <= 1'b0;
          pos_q <= in_none_i ? cpos : cpos + 6'd1;
          if (!in_none_i && cpos == 6'd63) begin
            state_q <= StStart;
          end else if (in_last_i) begin
            state_q <= StPad;
          end
        end
        StStart: state_q <= StRound;
        StRound: if (sts_i.round_last) state_q <= StFinish;
        StFinish: begin
          if (!pad_q) state_q <= StIdle;
          else if (pos_q == LenPos && two_q == 1'b0 && cpos != 6'd0) state_q <= StOut;
          else if (pos_q == LenPos) begin
            state_q <= StOut;
          end else begin
            state_q <= StPad;
          end
          idx_q <= '0;
        end
        StPad: begin
          pos_q <= pos_q + 6'd1;
          if (pos_q == 6'd63) begin
            two_q   <= 1'b1;
            state_q <= StStart;
          end else if (pos_q == LenPos - 6'd1 &&
                       (two_q || pos_q != cpos || 1'b1) &&
                       (two_q || cpos < LenPos)) begin
            state_q <= StLen;
          end
        end
        StLen: begin
          pos_q   <= LenPos;
          state_q <= StStart;
        end
        StOut: if (out_ready_i) begin
          idx_q <= idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            state_q <= StIdle;
            pad_q   <= 1'b0;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/sha256_chk.sv */
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Output ordering and handshake checks on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [39:0] m_axis_tdata_o,
  input wire logic        m_axis_tlast_o
);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(m_axis_tvalid_o && s_axis_tready_o)) else $error("input taken during output");

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tdata_o[34:32] == 3'd7)))
    else $error("tlast mismatch");

  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |=>
    (m_axis_tvalid_o && m_axis_tdata_o[34:32] == $past(m_axis_tdata_o[34:32]) + 3'd1))
    else $error("word index skip");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o))
    else $error("payload changed");

endmodule

bind sha256_byte_stream_hasher sha256_chk u_chk (.*);

`default_nettype wire

/* tb/sv/sha256_digest_checker.sv */
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches both streams, hashes accepted bytes itself and compares each digest
// word with the oldest predicted word.
// ----------------------------------------------------------------------------
module sha256_digest_checker
  import sha256_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [7:0]  s_data_i,
  input  logic        s_last_i,
  input  logic        s_user_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [39:0] m_data_i,
  input  logic        m_last_i,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_item_t;

  localparam logic [31:0] KTab [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam logic [31:0] HInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  logic [31:0]  hash_q [8];
  logic [31:0]  blk_q [16];
  logic [60:0]  nbytes_q;
  digest_item_t digest_q [$];
  int           errors;

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic put_byte(int pos, logic [7:0] b);
    blk_q[pos[5:2]][(3 - pos[1:0]) * 8 +: 8] = b;
  endtask

  task automatic compress_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wt, s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk_q[i];
    for (int i = 0; i < 8; i++) v[i] = hash_q[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        s0 = ror(w[(t+1)%16], 7) ^ ror(w[(t+1)%16], 18) ^ (w[(t+1)%16] >> 3);
        s1 = ror(w[(t+14)%16], 17) ^ ror(w[(t+14)%16], 19) ^ (w[(t+14)%16] >> 10);
        wt = w[t%16] + s0 + w[(t+9)%16] + s1;
        w[t%16] = wt;
      end
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTab[t] + wt;
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_q[i] += v[i];
  endtask

  task automatic hash_request(logic [7:0] b, logic last, logic none);
    int pos;
    logic [63:0] bits;
    digest_item_t it;
    if (!none) begin
      pos = nbytes_q[5:0];
      put_byte(pos, b);
      nbytes_q = nbytes_q + 1;
      if (pos == 63) compress_block();
    end
    if (last) begin
      bits = {nbytes_q, 3'b000};
      pos = nbytes_q[5:0];
      put_byte(pos, PadByte);
      pos++;
      if (pos > 56) begin
        while (pos < 64) begin put_byte(pos, 8'h00); pos++; end
        compress_block();
        pos = 0;
      end
      while (pos < 56) begin put_byte(pos, 8'h00); pos++; end
      blk_q[14] = bits[63:32];
      blk_q[15] = bits[31:0];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        it.word = hash_q[i];
        it.idx  = i[2:0];
        it.last = (i == 7);
        digest_q = {digest_q, it};
      end
      for (int i = 0; i < 8; i++) hash_q[i] = HInit[i];
      nbytes_q = '0;
    end
  endtask

  initial begin
    errors = 0;
    nbytes_q = '0;
    for (int i = 0; i < 8; i++) hash_q[i] = HInit[i];
    for (int i = 0; i < 16; i++) blk_q[i] = '0;
  end

  always @(posedge clk_i) begin
    digest_item_t got, exp_it;
    if (rst_ni) begin
      if (s_valid_i && s_ready_i) hash_request(s_data_i, s_last_i, s_user_i);
      if (m_valid_i && m_ready_i) begin
        got.word = m_data_i[31:0];
        got.idx  = m_data_i[34:32];
        got.last = m_last_i;
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest word, expected none, actual %h", $realtime, got);
          errors++;
        end else begin
          exp_it = digest_q.pop_front();
          if (got !== exp_it || m_data_i[39:35] !== 5'd0) begin
            $display("%0t: digest mismatch, expected %h_%0d_%0d, actual %h_%0d_%0d",
                     $realtime, exp_it.word, exp_it.idx, exp_it.last,
                     got.word, got.idx, got.last);
            errors++;
          end
        end
      end
    end
  end

  assign errors_o  = errors;
  assign pending_o = digest_q.size();
endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher testbench
// Feeds directed and random messages with random gaps and back-pressure;
// the checker predicts every digest word.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i, rst_ni;
  logic        s_valid, s_ready, s_last, s_user;
  logic [7:0]  s_data;
  logic        m_valid, m_ready, m_last;
  logic [39:0] m_data;
  int          errors, pending;
  int          sent;
  longint      cycles;

  sha256_byte_stream_hasher DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tlast_i(s_last), .s_axis_tuser_i(s_user),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tlast_o(m_last)
  );

  sha256_digest_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_valid_i(s_valid), .s_ready_i(s_ready), .s_data_i(s_data),
    .s_last_i(s_last), .s_user_i(s_user),
    .m_valid_i(m_valid), .m_ready_i(m_ready), .m_data_i(m_data),
    .m_last_i(m_last), .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 2000000) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) sent = 0;
    else if (s_valid && s_ready) sent++;
  end

  // one request per call; gap drawn before it
  task automatic send_byte(logic [7:0] b, logic last, logic none);
    int gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_last  <= last;
    s_user  <= none;
    do @(posedge clk_i); while (!s_ready);
  endtask

  task automatic send_message(int len, bit fixed, logic [7:0] val, bit noise);
    for (int i = 0; i < len; i++) begin
      if (noise && $urandom_range(0, 9) == 0) send_byte(8'($urandom), 1'b0, 1'b1);
      send_byte(fixed ? val : 8'($urandom), (i == len - 1), 1'b0);
    end
  endtask

  initial begin
    int len;
    int bnd [5];
    rst_ni = 1'b0;
    s_valid = 1'b0; s_data = '0; s_last = 1'b0; s_user = 1'b0;
    bnd = '{55, 56, 63, 64, 119};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // empty message, with and without a preceding no-data request
    send_byte(8'hff, 1'b1, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h5a, 1'b1, 1'b1);
    send_message(1, 1'b1, 8'h00, 1'b0);
    send_message(1, 1'b1, 8'hff, 1'b0);
    send_message(3, 1'b0, 8'h00, 1'b0);
    send_message(4, 1'b1, 8'hff, 1'b0);
    send_byte(8'h61, 1'b0, 1'b0);
    send_byte(8'h00, 1'b1, 1'b1);
    send_message(6, 1'b0, 8'h00, 1'b0);
    // padding boundaries: 55, 56, 63, 64 and 119 bytes
    foreach (bnd[k]) send_message(bnd[k], 1'b0, 8'h00, 1'b1);
    while (sent < 420) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 130) : $urandom_range(1, 12);
      send_message(len, 1'b0, 8'h00, 1'b1);
      if ($urandom_range(0, 7) == 0) send_byte(8'($urandom), 1'b1, 1'b1);
    end
    s_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    int stall;
    m_ready = 1'b0;
    @(posedge rst_ni);
    repeat (400) @(posedge clk_i);
    m_ready <= 1'b0;
    repeat (3000) @(posedge clk_i);
    forever begin
      stall = $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!m_valid);
    end
  end
endmodule

/* sim.f */
rtl/sha256_pkg.sv
rtl/sha256_dp.sv
rtl/sha256_ctrl.sv
rtl/sha256_byte_stream_hasher.sv
rtl/sha256_chk.sv
tb/sv/sha256_digest_checker.sv
tb/sv/testbench.sv
